FILE: rtl/crti_pkg.sv
package crti_pkg;

   // Table geometry and fixed-point format
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 7;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int ACC_W       = 64;
   localparam int COEF_W      = 40;
   localparam int CSR_AW      = 3;

   // Divider sizing: |x - x_base| and |x_hi - x_lo| stay below 2^32
   localparam int MAG_W   = 32;
   localparam int DVD_W   = MAG_W + FRAC_BITS;
   localparam int MU_W    = DVD_W + 1;
   localparam int DCNT_W  = $clog2(DVD_W + 1);

   // Input function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Register indexes (paddr bit 2)
   localparam logic REG_POINT_COUNT = 1'b0;
   localparam logic REG_EXTRAP_MODE = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_EMPTY      = 2'd1;
   localparam logic [1:0] STATUS_ZERO_WIDTH = 2'd2;

   // Datapath operations
   localparam logic [3:0] OP_NOP      = 4'd0;
   localparam logic [3:0] OP_TAKE     = 4'd1;
   localparam logic [3:0] OP_CAP_X0   = 4'd2;
   localparam logic [3:0] OP_CAP_LO   = 4'd3;
   localparam logic [3:0] OP_CAP_HI   = 4'd4;
   localparam logic [3:0] OP_CAP_YM   = 4'd5;
   localparam logic [3:0] OP_CAP_YP   = 4'd6;
   localparam logic [3:0] OP_DIV      = 4'd7;
   localparam logic [3:0] OP_EDGE     = 4'd8;
   localparam logic [3:0] OP_COEF     = 4'd9;
   localparam logic [3:0] OP_MUL      = 4'd10;
   localparam logic [3:0] OP_EMIT_ERR = 4'd11;
   localparam logic [3:0] OP_EMIT_ONE = 4'd12;
   localparam logic [3:0] OP_EMIT_RES = 4'd13;

   // Addend chosen for a multiply-accumulate step
   localparam logic [1:0] ADD_C2     = 2'd0;
   localparam logic [1:0] ADD_C1     = 2'd1;
   localparam logic [1:0] ADD_TWO_Y1 = 2'd2;
   localparam logic [1:0] ADD_YBASE  = 2'd3;

   localparam logic signed [ACC_W-1:0] CLAMP_POS = 64'sh4000_0000_0000_0000;
   localparam logic signed [ACC_W-1:0] CLAMP_NEG = -64'sh4000_0000_0000_0000;
   localparam logic signed [ACC_W-1:0] SAT_POS   = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] SAT_NEG   = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      logic [3:0]       op;
      logic [IDX_W-1:0] x_addr;
      logic [IDX_W-1:0] y_addr;
      logic             at_upper;
      logic             cubic;
      logic             mirror_lo;
      logic             mirror_hi;
      logic [1:0]       addend;
      logic [1:0]       status;
   } dp_cmd_type;

   typedef struct packed {
      logic x_le_x0;
      logic x_ge_rd;
      logic rd_ge_x;
      logic d_zero;
      logic div_done;
      logic mul_done;
   } dp_stat_type;

   function automatic logic signed [ACC_W-1:0] clamp62(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = v;
      if (v > CLAMP_POS) r = CLAMP_POS;
      if (v < CLAMP_NEG) r = CLAMP_NEG;
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = v;
      if (v > SAT_POS) r = SAT_POS;
      if (v < SAT_NEG) r = SAT_NEG;
      return r[DATA_W-1:0];
   endfunction

endpackage

FILE: rtl/crti_ram.sv
module crti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/crti_div.sv
module crti_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [crti_pkg::MAG_W:0]     num,
   input  logic signed [crti_pkg::MAG_W:0]     den,
   output logic                                done,
   output logic signed [crti_pkg::MU_W-1:0]    quot
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [crti_pkg::DCNT_W-1:0]       cnt_ff;
   logic [crti_pkg::MAG_W:0]          rem_ff;
   logic [crti_pkg::DVD_W-1:0]        dvd_ff;
   logic [crti_pkg::MAG_W-1:0]        dvs_ff;
   logic                              neg_ff;

   logic signed [crti_pkg::MAG_W:0]   num_abs;
   logic signed [crti_pkg::MAG_W:0]   den_abs;
   logic [crti_pkg::MAG_W:0]          rem_sh;
   logic                              fits;
   logic [crti_pkg::MAG_W:0]          rem_in;
   logic [crti_pkg::DVD_W-1:0]        dvd_in;

   assign num_abs = num[crti_pkg::MAG_W] ? -num : num;
   assign den_abs = den[crti_pkg::MAG_W] ? -den : den;

   // One restoring step: shift in the next dividend bit, subtract when it fits
   assign rem_sh = {rem_ff[crti_pkg::MAG_W-1:0], dvd_ff[crti_pkg::DVD_W-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};
   assign rem_in = fits ? rem_sh - {1'b0, dvs_ff} : rem_sh;
   assign dvd_in = {dvd_ff[crti_pkg::DVD_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= crti_pkg::DCNT_W'(crti_pkg::DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - crti_pkg::DCNT_W'(1);
            if (cnt_ff == crti_pkg::DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operands load at start, then advance one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= {num_abs[crti_pkg::MAG_W-1:0], {crti_pkg::FRAC_BITS{1'b0}}};
         dvs_ff <= den_abs[crti_pkg::MAG_W-1:0];
         neg_ff <= num[crti_pkg::MAG_W] ^ den[crti_pkg::MAG_W];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});

endmodule

FILE: rtl/crti_dp.sv
module crti_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  crti_pkg::dp_cmd_type                cmd,
   input  logic signed [crti_pkg::DATA_W-1:0]  req_x_value,
   input  logic signed [crti_pkg::DATA_W-1:0]  x_rdata,
   input  logic signed [crti_pkg::DATA_W-1:0]  y_rdata,
   output crti_pkg::dp_stat_type               stat,
   output logic                                rsp_valid,
   output logic signed [crti_pkg::DATA_W-1:0]  rsp_y_result,
   output logic [1:0]                          rsp_status
);

   localparam int AW = crti_pkg::ACC_W;
   localparam int CW = crti_pkg::COEF_W;
   localparam int DW = crti_pkg::DATA_W;
   localparam int PW = 2 * AW;

   // Breakpoint and query registers
   logic signed [DW-1:0] qx_ff, x0_ff, xlo_ff, xhi_ff, ylo_ff, yhi_ff, ym_ff, yp_ff;
   logic signed [CW-1:0] y0_ff, y3_ff, c1_ff, c2_ff;
   logic signed [AW-1:0] acc_ff, mu_ff, add_ff, qt_ff;

   // Multiplier sequencing
   logic                 mbusy_ff, mdone_ff, mneg_ff;
   logic [2:0]           mstep_ff;
   logic [1:0]           pcode_ff;
   logic [AW-1:0]        ma_ff, mb_ff, p_ff;
   logic [PW-1:0]        prod_ff;

   logic                 rsp_valid_ff;
   logic signed [DW-1:0] rsp_y_ff;
   logic [1:0]           rsp_status_ff;

   logic signed [crti_pkg::MAG_W:0]  div_num, div_den;
   logic signed [DW-1:0]             x_base;
   logic                             div_done;
   logic signed [crti_pkg::MU_W-1:0] div_quot;

   logic signed [CW-1:0] ylo_e, yhi_e, ym_e, yp_e, y0_in, y3_in, c1_in, c2_in, c3_in;
   logic signed [AW-1:0] addend_in, mu_abs, acc_abs, half, qt_in, mag_s;
   logic [31:0]          a_part, b_part;
   logic [PW-1:0]        p_shift, r_full;
   logic                 over;

   // Status for the controller
   assign stat.x_le_x0  = qx_ff <= x0_ff;
   assign stat.x_ge_rd  = qx_ff >= x_rdata;
   assign stat.rd_ge_x  = x_rdata >= qx_ff;
   assign stat.d_zero   = xhi_ff == xlo_ff;
   assign stat.div_done = div_done;
   assign stat.mul_done = mdone_ff;

   // mu = ((x - x_base) << FRAC_BITS) / (x_hi - x_lo)
   assign x_base  = cmd.at_upper ? xhi_ff : xlo_ff;
   assign div_num = {qx_ff[DW-1], qx_ff} - {x_base[DW-1], x_base};
   assign div_den = {xhi_ff[DW-1], xhi_ff} - {xlo_ff[DW-1], xlo_ff};

   crti_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == crti_pkg::OP_DIV),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Neighbors, mirrored at the table ends
   assign ylo_e = CW'(ylo_ff);
   assign yhi_e = CW'(yhi_ff);
   assign ym_e  = CW'(ym_ff);
   assign yp_e  = CW'(yp_ff);
   assign y0_in = cmd.mirror_lo ? (ylo_e <<< 1) - yhi_e : ym_e;
   assign y3_in = cmd.mirror_hi ? (yhi_e <<< 1) - ylo_e : yp_e;

   // Cubic coefficients
   assign c1_in = yhi_e - y0_ff;
   assign c2_in = (y0_ff <<< 1) - ((ylo_e <<< 2) + ylo_e) + (yhi_e <<< 2) - y3_ff;
   assign c3_in = ((ylo_e <<< 1) + ylo_e) - ((yhi_e <<< 1) + yhi_e) + y3_ff - y0_ff;

   always_comb begin
      case (cmd.addend)
         crti_pkg::ADD_C2:     addend_in = AW'(c2_ff);
         crti_pkg::ADD_C1:     addend_in = AW'(c1_ff);
         crti_pkg::ADD_TWO_Y1: addend_in = AW'(ylo_e) <<< 1;
         crti_pkg::ADD_YBASE:  addend_in = cmd.at_upper ? AW'(yhi_e) : AW'(ylo_e);
         default:              addend_in = '0;
      endcase
   end

   assign mu_abs  = mu_ff[AW-1] ? -mu_ff : mu_ff;
   assign acc_abs = acc_ff[AW-1] ? -acc_ff : acc_ff;

   // Partial products of the 64 x 64 magnitude multiply, 32 x 32 each
   assign a_part = mstep_ff[1] ? ma_ff[AW-1:32] : ma_ff[31:0];
   assign b_part = mstep_ff[0] ? mb_ff[AW-1:32] : mb_ff[31:0];

   always_comb begin
      case (pcode_ff)
         2'd0:    p_shift = {64'b0, p_ff};
         2'd1:    p_shift = {32'b0, p_ff, 32'b0};
         2'd2:    p_shift = {p_ff, 64'b0};
         default: p_shift = '0;
      endcase
   end

   // Drop fraction bits, clamp the magnitude at 2^62, apply sign
   assign r_full = prod_ff >> crti_pkg::FRAC_BITS;
   assign over   = (|r_full[PW-1:63]) || (r_full[62] && (|r_full[61:0]));
   assign mag_s  = over ? crti_pkg::CLAMP_POS : $signed({1'b0, r_full[62:0]});
   assign qt_in  = mneg_ff ? -mag_s : mag_s;

   // Halve toward zero
   assign half = $signed(acc_ff + AW'(acc_ff[AW-1])) >>> 1;

   // Operand and coefficient registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         crti_pkg::OP_TAKE:   qx_ff <= req_x_value;
         crti_pkg::OP_CAP_X0: x0_ff <= x_rdata;
         crti_pkg::OP_CAP_LO: begin
            xlo_ff <= x_rdata;
            ylo_ff <= y_rdata;
         end
         crti_pkg::OP_CAP_HI: begin
            xhi_ff <= x_rdata;
            yhi_ff <= y_rdata;
         end
         crti_pkg::OP_CAP_YM: ym_ff <= y_rdata;
         crti_pkg::OP_CAP_YP: yp_ff <= y_rdata;
         crti_pkg::OP_EDGE: begin
            y0_ff <= y0_in;
            y3_ff <= y3_in;
         end
         crti_pkg::OP_COEF: begin
            c1_ff <= c1_in;
            c2_ff <= c2_in;
         end
         default: begin
         end
      endcase
      if (div_done) begin
         mu_ff <= AW'(div_quot);
      end
   end

   // Multiply-accumulate: acc = clamp62(addend + qmul(mu, acc))
   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
         mstep_ff <= '0;
      end else begin
         mdone_ff <= 1'b0;
         if (cmd.op == crti_pkg::OP_MUL) begin
            mbusy_ff <= 1'b1;
            mstep_ff <= '0;
         end else if (mbusy_ff) begin
            mstep_ff <= mstep_ff + 3'd1;
            if (mstep_ff == 3'd6) begin
               mbusy_ff <= 1'b0;
               mdone_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == crti_pkg::OP_COEF) begin
         acc_ff <= cmd.cubic ? AW'(c3_in) : AW'(yhi_e - ylo_e);
      end else if (cmd.op == crti_pkg::OP_MUL) begin
         ma_ff   <= mu_abs;
         mb_ff   <= acc_abs;
         mneg_ff <= mu_ff[AW-1] ^ acc_ff[AW-1];
         add_ff  <= addend_in;
         prod_ff <= '0;
      end else if (mbusy_ff) begin
         if (mstep_ff < 3'd4) begin
            p_ff     <= AW'(a_part) * AW'(b_part);
            pcode_ff <= {mstep_ff[1] & mstep_ff[0], mstep_ff[1] ^ mstep_ff[0]};
         end
         if (mstep_ff >= 3'd1 && mstep_ff <= 3'd4) begin
            prod_ff <= prod_ff + p_shift;
         end
         if (mstep_ff == 3'd5) begin
            qt_ff <= qt_in;
         end
         if (mstep_ff == 3'd6) begin
            acc_ff <= crti_pkg::clamp62(add_ff + qt_ff);
         end
      end
   end

   // Result register: one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op == crti_pkg::OP_EMIT_ERR) ||
                         (cmd.op == crti_pkg::OP_EMIT_ONE) ||
                         (cmd.op == crti_pkg::OP_EMIT_RES);
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         crti_pkg::OP_EMIT_ERR: begin
            rsp_y_ff      <= '0;
            rsp_status_ff <= cmd.status;
         end
         crti_pkg::OP_EMIT_ONE: begin
            rsp_y_ff      <= y_rdata;
            rsp_status_ff <= crti_pkg::STATUS_OK;
         end
         crti_pkg::OP_EMIT_RES: begin
            rsp_y_ff      <= crti_pkg::sat32(cmd.cubic ? half : acc_ff);
            rsp_status_ff <= crti_pkg::STATUS_OK;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_y_result = rsp_y_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

FILE: rtl/crti_ctrl.sv
module crti_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          req_func,
   input  logic [crti_pkg::CNT_W-1:0]    cfg_count,
   input  logic                          cfg_mode,
   input  crti_pkg::dp_stat_type         stat,
   output logic                          busy,
   output crti_pkg::dp_cmd_type          cmd
);

   localparam int NW = crti_pkg::CNT_W;
   localparam int IW = crti_pkg::IDX_W;

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_CHECK    = 5'd1;
   localparam logic [4:0] ST_ONE      = 5'd2;
   localparam logic [4:0] ST_RD_LAST  = 5'd3;
   localparam logic [4:0] ST_CMP      = 5'd4;
   localparam logic [4:0] ST_SCAN     = 5'd5;
   localparam logic [4:0] ST_F0       = 5'd6;
   localparam logic [4:0] ST_F1       = 5'd7;
   localparam logic [4:0] ST_F2       = 5'd8;
   localparam logic [4:0] ST_F3       = 5'd9;
   localparam logic [4:0] ST_F4       = 5'd10;
   localparam logic [4:0] ST_PREP     = 5'd11;
   localparam logic [4:0] ST_DIV      = 5'd12;
   localparam logic [4:0] ST_EDGE     = 5'd13;
   localparam logic [4:0] ST_COEF     = 5'd14;
   localparam logic [4:0] ST_MUL_GO   = 5'd15;
   localparam logic [4:0] ST_MUL_WAIT = 5'd16;
   localparam logic [4:0] ST_FIN      = 5'd17;

   logic [4:0]    state_ff, state_in;
   logic [NW-1:0] n_ff, n_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          mode_ff, mode_in;
   logic          cubic_ff, cubic_in;
   logic          upper_ff, upper_in;
   logic [1:0]    k_ff, k_in;

   logic [IW-1:0] last_idx;
   logic [IW-1:0] pen_idx;

   assign last_idx = IW'(n_ff - NW'(1));
   assign pen_idx  = IW'(n_ff - NW'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
         idx_ff   <= '0;
         mode_ff  <= 1'b0;
         cubic_ff <= 1'b0;
         upper_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         idx_ff   <= idx_in;
         mode_ff  <= mode_in;
         cubic_ff <= cubic_in;
         upper_ff <= upper_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      mode_in  = mode_ff;
      cubic_in = cubic_ff;
      upper_in = upper_ff;
      k_in     = k_ff;

      cmd           = '0;
      cmd.op        = crti_pkg::OP_NOP;
      cmd.at_upper  = upper_ff;
      cmd.cubic     = cubic_ff;
      cmd.mirror_lo = idx_ff == '0;
      cmd.mirror_hi = ({1'b0, idx_ff} + NW'(2)) >= n_ff;
      cmd.status    = crti_pkg::STATUS_OK;
      if (!cubic_ff) begin
         cmd.addend = crti_pkg::ADD_YBASE;
      end else if (k_ff == 2'd0) begin
         cmd.addend = crti_pkg::ADD_C2;
      end else if (k_ff == 2'd1) begin
         cmd.addend = crti_pkg::ADD_C1;
      end else begin
         cmd.addend = crti_pkg::ADD_TWO_Y1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start && req_func == crti_pkg::FUNC_QUERY) begin
               cmd.op   = crti_pkg::OP_TAKE;
               n_in     = (cfg_count > NW'(crti_pkg::TABLE_DEPTH)) ?
                          NW'(crti_pkg::TABLE_DEPTH) : cfg_count;
               mode_in  = cfg_mode;
               state_in = ST_CHECK;
            end
         end
         // Empty table, single point, or start the range check
         ST_CHECK: begin
            if (n_ff == '0) begin
               cmd.op     = crti_pkg::OP_EMIT_ERR;
               cmd.status = crti_pkg::STATUS_EMPTY;
               state_in   = ST_IDLE;
            end else if (n_ff == NW'(1)) begin
               cmd.y_addr = '0;
               state_in   = ST_ONE;
            end else begin
               cmd.x_addr = '0;
               state_in   = ST_RD_LAST;
            end
         end
         ST_ONE: begin
            cmd.op   = crti_pkg::OP_EMIT_ONE;
            state_in = ST_IDLE;
         end
         ST_RD_LAST: begin
            cmd.op     = crti_pkg::OP_CAP_X0;
            cmd.x_addr = last_idx;
            state_in   = ST_CMP;
         end
         // Pick the interval: below the table, above it, or scan
         ST_CMP: begin
            if (stat.x_le_x0) begin
               idx_in   = '0;
               upper_in = 1'b0;
               cubic_in = mode_ff;
               state_in = ST_F0;
            end else if (stat.x_ge_rd) begin
               idx_in   = pen_idx;
               upper_in = !mode_ff;
               cubic_in = mode_ff;
               state_in = ST_F0;
            end else begin
               idx_in     = IW'(1);
               cmd.x_addr = IW'(1);
               upper_in   = 1'b0;
               cubic_in   = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         // One entry per cycle; the next read is always in flight
         ST_SCAN: begin
            cmd.x_addr = idx_ff + IW'(1);
            if (stat.rd_ge_x) begin
               idx_in   = idx_ff - IW'(1);
               state_in = ST_F0;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_F0: begin
            cmd.x_addr = idx_ff;
            cmd.y_addr = idx_ff;
            state_in   = ST_F1;
         end
         ST_F1: begin
            cmd.op     = crti_pkg::OP_CAP_LO;
            cmd.x_addr = idx_ff + IW'(1);
            cmd.y_addr = idx_ff + IW'(1);
            state_in   = ST_F2;
         end
         ST_F2: begin
            cmd.op     = crti_pkg::OP_CAP_HI;
            cmd.y_addr = idx_ff - IW'(1);
            state_in   = ST_F3;
         end
         ST_F3: begin
            cmd.op     = crti_pkg::OP_CAP_YM;
            cmd.y_addr = idx_ff + IW'(2);
            state_in   = ST_F4;
         end
         ST_F4: begin
            cmd.op   = crti_pkg::OP_CAP_YP;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            if (stat.d_zero) begin
               cmd.op     = crti_pkg::OP_EMIT_ERR;
               cmd.status = crti_pkg::STATUS_ZERO_WIDTH;
               state_in   = ST_IDLE;
            end else begin
               cmd.op   = crti_pkg::OP_DIV;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            cmd.op   = crti_pkg::OP_EDGE;
            state_in = ST_COEF;
         end
         ST_COEF: begin
            cmd.op   = crti_pkg::OP_COEF;
            k_in     = '0;
            state_in = ST_MUL_GO;
         end
         // Horner steps: three for the cubic, one for the end slope
         ST_MUL_GO: begin
            cmd.op   = crti_pkg::OP_MUL;
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (stat.mul_done) begin
               if (!cubic_ff || k_ff == 2'd2) begin
                  state_in = ST_FIN;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_MUL_GO;
               end
            end
         end
         ST_FIN: begin
            cmd.op   = crti_pkg::OP_EMIT_RES;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

endmodule

FILE: rtl/catmull_rom_table_interpolator_unit.sv
// Catmull-Rom table interpolator.
// Input channel: an item is taken when start is high and busy is low.
//   req_func = load writes breakpoint (req_x_value, req_y_value) at
//   req_point_index; it gives no result, and busy stays low.
//   req_func = query interpolates y at req_x_value and gives one result.
// Result channel: rsp_valid is high for one cycle with rsp_y_result and
//   rsp_status; the receiver cannot stall, so nothing waits on it.
// Query datapath: the linear scan reads one x entry per cycle from the x
//   memory, mu takes one quotient bit per cycle, and each of the up to three
//   Horner steps runs on a shared 32 x 32 multiplier.
//   One query is in work at a time; busy is high throughout.
// Configuration: APB registers point_count (0x0), extrapolation_mode (0x4).
//   Write them only while busy is low; the block itself does not enforce it.
// Reset clears the controller and both registers; breakpoint memories are
//   not cleared and must be loaded before they are queried.
module catmull_rom_table_interpolator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [crti_pkg::IDX_W-1:0]          req_point_index,
   input  logic signed [crti_pkg::DATA_W-1:0]  req_x_value,
   input  logic signed [crti_pkg::DATA_W-1:0]  req_y_value,
   output logic                                rsp_valid,
   output logic signed [crti_pkg::DATA_W-1:0]  rsp_y_result,
   output logic [1:0]                          rsp_status,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [crti_pkg::CSR_AW-1:0]         paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic [crti_pkg::CNT_W-1:0]  count_ff;
   logic                        mode_ff;
   logic                        csr_wr;
   logic                        load_go;
   crti_pkg::dp_cmd_type        cmd;
   crti_pkg::dp_stat_type       stat;
   logic [crti_pkg::DATA_W-1:0] x_rdata;
   logic [crti_pkg::DATA_W-1:0] y_rdata;

   // Configuration registers
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mode_ff  <= 1'b0;
      end else if (csr_wr) begin
         if (paddr[2] == crti_pkg::REG_POINT_COUNT) begin
            count_ff <= pwdata[crti_pkg::CNT_W-1:0];
         end else begin
            mode_ff <= pwdata[0];
         end
      end
   end

   assign prdata = (paddr[2] == crti_pkg::REG_EXTRAP_MODE) ? {31'b0, mode_ff} :
                   {{(32 - crti_pkg::CNT_W){1'b0}}, count_ff};

   // Load transfers write both memories directly
   assign load_go = start && !busy && (req_func == crti_pkg::FUNC_LOAD);

   crti_ram #(.WIDTH(crti_pkg::DATA_W), .DEPTH(crti_pkg::TABLE_DEPTH)) u_x_ram (
      .clock   (clock),
      .wr_en   (load_go),
      .wr_addr (req_point_index),
      .wr_data (req_x_value),
      .rd_addr (cmd.x_addr),
      .rd_data (x_rdata)
   );

   crti_ram #(.WIDTH(crti_pkg::DATA_W), .DEPTH(crti_pkg::TABLE_DEPTH)) u_y_ram (
      .clock   (clock),
      .wr_en   (load_go),
      .wr_addr (req_point_index),
      .wr_data (req_y_value),
      .rd_addr (cmd.y_addr),
      .rd_data (y_rdata)
   );

   crti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .cfg_count (count_ff),
      .cfg_mode  (mode_ff),
      .stat      (stat),
      .busy      (busy),
      .cmd       (cmd)
   );

   crti_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_x_value  (req_x_value),
      .x_rdata      ($signed(x_rdata)),
      .y_rdata      ($signed(y_rdata)),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_y_result (rsp_y_result),
      .rsp_status   (rsp_status)
   );

   // A query keeps the block busy in the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == crti_pkg::FUNC_QUERY) |=> busy)
      else $error("query transfer did not make the block busy");

   // Results are single-cycle strobes
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // Error results carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != crti_pkg::STATUS_OK) |-> rsp_y_result == '0)
      else $error("error result with nonzero value");

   // Only defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == crti_pkg::STATUS_OK ||
                     rsp_status == crti_pkg::STATUS_EMPTY ||
                     rsp_status == crti_pkg::STATUS_ZERO_WIDTH))
      else $error("undefined status code");

endmodule

FILE: tb/sv/catmull_rom_table_interpolator_unit_test.sv
`timescale 1ns / 100ps

module catmull_rom_table_interpolator_unit_test;

   typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [5:0]        idx;
      logic signed [31:0] x;
      logic signed [31:0] y;
      bit                typed;
      logic signed [31:0] ey;
      logic [1:0]        est;
   } stim_row_type;

   typedef struct {
      logic signed [31:0] y;
      logic [1:0]         status;
   } spline_out_type;

   localparam longint Q_ONE    = 64'sd65536;
   localparam longint LIM62    = 64'sh4000_0000_0000_0000;
   localparam int     WATCHDOG = 10000;
   localparam int     DEPTH    = crti_pkg::TABLE_DEPTH;

   localparam logic [1:0] S_OK     = crti_pkg::STATUS_OK;
   localparam logic [1:0] S_EMPTY  = crti_pkg::STATUS_EMPTY;
   localparam logic [1:0] S_ZERO_W = crti_pkg::STATUS_ZERO_WIDTH;
   localparam logic       R_COUNT  = crti_pkg::REG_POINT_COUNT;
   localparam logic       R_MODE   = crti_pkg::REG_EXTRAP_MODE;
   localparam logic       F_LOAD   = crti_pkg::FUNC_LOAD;
   localparam logic       F_QUERY  = crti_pkg::FUNC_QUERY;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = F_LOAD;
   logic [crti_pkg::IDX_W-1:0] req_point_index = '0;
   logic signed [crti_pkg::DATA_W-1:0] req_x_value = '0;
   logic signed [crti_pkg::DATA_W-1:0] req_y_value = '0;
   logic rsp_valid;
   logic signed [crti_pkg::DATA_W-1:0] rsp_y_result;
   logic [1:0] rsp_status;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [crti_pkg::CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   catmull_rom_table_interpolator_unit dut (.*);

   always #1 clock = ~clock;

   // Shadow of the breakpoint table and registers
   logic signed [31:0] knot_x [DEPTH];
   logic signed [31:0] knot_y [DEPTH];
   bit                 knot_written [DEPTH];
   int unsigned        shadow_count = 0;
   bit                 shadow_cubic = 1'b0;

   spline_out_type pending_y [$];
   int mismatches = 0;
   int gap_pct = 0;
   int n_query = 0, n_load = 0, n_empty = 0, n_zero_w = 0, n_cfg = 0;

   function automatic longint clamp_62(longint v);
      if (v > LIM62) return LIM62;
      if (v < -LIM62) return -LIM62;
      return v;
   endfunction

   // Q16.16 product truncated toward zero, magnitude clamped
   function automatic longint q_mul(longint a, longint b);
      logic [127:0] p;
      logic [63:0]  ua, ub;
      longint       mag;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = p >> crti_pkg::FRAC_BITS;
      mag = (p > 128'(LIM62)) ? LIM62 : longint'(p[63:0]);
      return ((a < 0) != (b < 0)) ? -mag : mag;
   endfunction

   function automatic logic signed [31:0] sat_32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Expected result of a query at x under the current table and registers
   function automatic spline_out_type interpolate_y(logic signed [31:0] qx);
      spline_out_type r;
      longint x, d, mu, y0, y1, y2, y3, c1, c2, c3, t;
      int n, lo, hi, e, o;
      r.y = '0;
      r.status = S_OK;
      n = (shadow_count > DEPTH) ? DEPTH : shadow_count;
      x = qx;
      if (n == 0) begin
         r.status = S_EMPTY;
         return r;
      end
      if (n == 1) begin
         r.y = knot_y[0];
         return r;
      end
      if (!shadow_cubic && (x <= knot_x[0] || x >= knot_x[n-1])) begin
         if (x <= knot_x[0]) begin
            e = 0; o = 1;
         end else begin
            e = n - 1; o = n - 2;
         end
         d = (e == 0) ? longint'(knot_x[1]) - knot_x[0] : longint'(knot_x[n-1]) - knot_x[n-2];
         if (d == 0) begin
            r.status = S_ZERO_W;
            return r;
         end
         mu = ((x - knot_x[e]) * Q_ONE) / d;
         if (e == 0) t = q_mul(mu, longint'(knot_y[o]) - knot_y[e]);
         else        t = q_mul(mu, longint'(knot_y[e]) - knot_y[o]);
         r.y = sat_32(clamp_62(knot_y[e] + t));
         return r;
      end
      // Scan for the bracketing segment
      lo = n - 2; hi = n - 1;
      if (x <= knot_x[0]) begin
         lo = 0; hi = 1;
      end else if (x < knot_x[n-1]) begin
         for (int i = 1; i < n; i++) begin
            if (knot_x[i] >= x) begin
               lo = i - 1; hi = i;
               break;
            end
         end
      end
      d = longint'(knot_x[hi]) - knot_x[lo];
      if (d == 0) begin
         r.status = S_ZERO_W;
         return r;
      end
      mu = ((x - knot_x[lo]) * Q_ONE) / d;
      y1 = knot_y[lo];
      y2 = knot_y[hi];
      y0 = (lo == 0) ? 2 * y1 - y2 : longint'(knot_y[lo-1]);
      y3 = (hi + 1 >= n) ? 2 * y2 - y1 : longint'(knot_y[hi+1]);
      c1 = -y0 + y2;
      c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      c3 = -y0 + 3 * y1 - 3 * y2 + y3;
      t = clamp_62(c2 + q_mul(mu, c3));
      t = clamp_62(c1 + q_mul(mu, t));
      t = clamp_62(2 * y1 + q_mul(mu, t));
      r.y = sat_32(t / 2);
      return r;
   endfunction

   // Present one item and hold it until the transfer happens
   task automatic send_item(logic f, logic [5:0] idx, logic signed [31:0] x,
                            logic signed [31:0] y, bit typed, spline_out_type typed_out);
      spline_out_type r;
      if ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_func = f;
      req_point_index = idx;
      req_x_value = x;
      req_y_value = y;
      do @(posedge clock); while (busy);
      if (f == F_LOAD) begin
         knot_x[idx] = x;
         knot_y[idx] = y;
         knot_written[idx] = 1'b1;
         n_load++;
      end else begin
         r = typed ? typed_out : interpolate_y(x);
         if (r.status == S_EMPTY) n_empty++;
         if (r.status == S_ZERO_W) n_zero_w++;
         pending_y.push_back(r);
         n_query++;
      end
   endtask

   // Hold until every result is in and the block is idle
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_y.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_sel, logic [31:0] value);
      drain();
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = {reg_sel, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_sel == R_COUNT) shadow_count = value[6:0];
      else shadow_cubic = value[0];
      n_cfg++;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin
      spline_out_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_y.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result y=%h status=%0d", rsp_y_result, rsp_status);
         end else begin
            exp_r = pending_y.pop_front();
            if (rsp_y_result !== exp_r.y || rsp_status !== exp_r.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: y exp %h got %h, status exp %0d got %0d",
                           exp_r.y, rsp_y_result, exp_r.status, rsp_status);
            end
         end
      end
   end

   // End the run if nothing moves for too long
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   stim_row_type directed [] = '{
      '{ROW_QUERY, 6'd0, 32'sh0000_0000, 32'sh0, 1, 32'sh0, S_EMPTY},
      '{ROW_LOAD,  6'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh0, S_OK},
      '{ROW_CFG,   {5'd0, R_COUNT}, 32'sh0, 32'sd1, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh8000_0000, 32'sh0, 1, 32'sh8000_0000, S_OK},
      '{ROW_LOAD,  6'd1, 32'sh7FFF_FFFF, 32'sh0001_0000, 0, 32'sh0, S_OK},
      '{ROW_CFG,   {5'd0, R_COUNT}, 32'sh0, 32'sd2, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh0000_0000, 32'sh0, 1, 32'sh0, S_ZERO_W},
      '{ROW_LOAD,  6'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh8000_0000, 32'sh0, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh0000_0000, 32'sh0, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh7FFF_FFFF, 32'sh0, 0, 32'sh0, S_OK},
      '{ROW_CFG,   {5'd0, R_MODE}, 32'sh0, 32'sd1, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh0000_0000, 32'sh0, 0, 32'sh0, S_OK},
      '{ROW_LOAD,  6'd0, 32'shFFFF_0000, 32'sh0000_0000, 0, 32'sh0, S_OK},
      '{ROW_LOAD,  6'd1, 32'sh0000_0000, 32'sh0001_0000, 0, 32'sh0, S_OK},
      '{ROW_LOAD,  6'd2, 32'sh0001_0000, 32'sh0004_0000, 0, 32'sh0, S_OK},
      '{ROW_LOAD,  6'd3, 32'sh0003_0000, 32'shFFFF_0000, 0, 32'sh0, S_OK},
      '{ROW_CFG,   {5'd0, R_COUNT}, 32'sh0, 32'sd4, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh0000_8000, 32'sh0, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh0002_0000, 32'sh0, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh0010_0000, 32'sh0, 0, 32'sh0, S_OK},
      '{ROW_CFG,   {5'd0, R_MODE}, 32'sh0, 32'sd0, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh0010_0000, 32'sh0, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh8000_0000, 32'sh0, 0, 32'sh0, S_OK},
      '{ROW_LOAD,  6'd63, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 0, 32'sh0, S_OK},
      '{ROW_LOAD,  6'd2, 32'shFFFF_8000, 32'sh0004_0000, 0, 32'sh0, S_OK},
      '{ROW_QUERY, 6'd0, 32'sh0000_8000, 32'sh0, 0, 32'sh0, S_OK}
   };

   initial begin
      spline_out_type typed_out, none;
      longint pts [DEPTH];
      longint tmp, span, qx;
      int n, m, i, j, items, pick;
      bit wide;
      none = '{y: '0, status: S_OK};

      // Hold reset, then release at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table
      foreach (directed[k]) begin
         typed_out = '{y: directed[k].ey, status: directed[k].est};
         case (directed[k].kind)
            ROW_CFG: begin
               csr_write(directed[k].idx[0], directed[k].y);
            end
            ROW_LOAD: begin
               send_item(F_LOAD, directed[k].idx, directed[k].x, directed[k].y, 0, none);
            end
            default: begin
               send_item(F_QUERY, directed[k].idx, directed[k].x, directed[k].y,
                         directed[k].typed, typed_out);
            end
         endcase
      end

      // Random phases: new table and settings, then mostly queries
      items = 0;
      for (int ph = 0; items < 1700; ph++) begin
         case (ph % 4)
            0: gap_pct = 0;
            1: gap_pct = 51;
            2: gap_pct = 10;
            default: gap_pct = 51;
         endcase
         pick = $urandom_range(99);
         if (pick < 5) n = 0;
         else if (pick < 10) n = 1;
         else if (pick < 14) n = 64;
         else if (pick < 17) n = $urandom_range(65, 127);
         else n = $urandom_range(2, 12);
         if (ph == 3) n = 127;
         m = (n > DEPTH) ? DEPTH : n;
         csr_write(R_COUNT, n);
         csr_write(R_MODE, $urandom_range(1));

         // Ascending abscissas, sometimes with a repeat or out of order
         wide = ($urandom_range(3) == 0);
         span = wide ? 64'sh1_0000_0000 : 64'sd1 << $urandom_range(12, 26);
         for (i = 0; i < m; i++)
            pts[i] = wide ? longint'($signed($urandom))
                          : longint'($urandom_range(0, span)) - span / 2;
         for (i = 1; i < m; i++) begin
            tmp = pts[i];
            for (j = i - 1; j >= 0 && pts[j] > tmp; j--) pts[j+1] = pts[j];
            pts[j+1] = tmp;
         end
         if (m > 2 && $urandom_range(4) == 0) begin
            j = $urandom_range(1, m - 1);
            pts[j] = pts[j-1];
         end
         if (m > 2 && $urandom_range(9) == 0) begin
            j = $urandom_range(0, m - 2);
            tmp = pts[j]; pts[j] = pts[j+1] + 1; pts[j+1] = tmp;
         end
         for (i = 0; i < m; i++) begin
            send_item(F_LOAD, i[5:0], sat_32(pts[i]),
                      wide ? $signed($urandom) : $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                      0, none);
            items++;
         end

         // Queries inside, on and around the table, with stray loads mixed in
         repeat ($urandom_range(10, 30)) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               i = $urandom_range(0, 63);
               if (i >= m || knot_written[i]) begin
                  send_item(F_LOAD, i[5:0], $signed($urandom), $signed($urandom), 0, none);
                  items++;
               end
               continue;
            end
            if (m == 0 || pick < 20) qx = longint'($signed($urandom));
            else if (pick < 35) qx = knot_x[$urandom_range(0, m - 1)];
            else if (pick < 50)
               qx = ($urandom_range(1) ? longint'(knot_x[m-1]) : longint'(knot_x[0]))
                    + longint'($urandom_range(0, span)) - span / 2;
            else begin
               i = $urandom_range(0, m - 1);
               j = $urandom_range(0, m - 1);
               qx = knot_x[i] + (longint'(knot_x[j]) - knot_x[i])
                    * longint'($urandom_range(0, 255)) / 256;
            end
            send_item(F_QUERY, 6'($urandom_range(63)), sat_32(qx), $signed($urandom), 0, none);
            items++;
         end

         // Let every result come back before the next items
         if (ph == 5) drain();
      end

      drain();
      repeat (160) @(posedge clock);
      $display("Covered %0d queries and %0d loads over %0d register writes;", n_query, n_load,
               n_cfg);
      $display("%0d empty-table and %0d zero-width results, %0d mismatches.", n_empty,
               n_zero_w, mismatches);
      if (mismatches == 0 && pending_y.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
